// File: sv/krt_pkg.sv
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants for the keyed record table: record layout,
// command and status codes, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
`default_nettype none

package krt_pkg;

    // table geometry
    localparam int unsigned DEPTH   = 64;
    localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

    // field widths
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned TAG_W   = 64;
    localparam int unsigned SCORE_W = 24;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_APPEND = 3'd0;
    localparam cmd_t CMD_FIND   = 3'd1;
    localparam cmd_t CMD_UPDATE = 3'd2;
    localparam cmd_t CMD_DELETE = 3'd3;
    localparam cmd_t CMD_DUMP   = 3'd4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    // one stored record
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic [SCORE_W-1:0]      score;
    } rec_t;

    localparam int unsigned REC_W = $bits(rec_t);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_EMIT,
        S_SHIFT,
        S_DUMP
    } state_t;

    // result beat offered by the sequencer
    typedef struct packed {
        logic    valid;
        status_t status;
        rec_t    rec;
        logic    last;
    } emit_t;

    // record store access
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        rec_t              wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    // sequencer status seen by the top level
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } ctrl_stat_t;

endpackage

`default_nettype wire

// File: sv/krt_ram.sv
// ----------------------------------------------------------------------------
// krt_ram
// Generic single write port, single read port memory with registered read
// data. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_ram #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6,
    parameter int unsigned DATA_W = 120
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/krt_ctrl.sv
// ----------------------------------------------------------------------------
// krt_ctrl
// Command sequencer: walks the record store one entry a cycle (a dump only
// while the output is free) through one key comparator, performs append,
// update and delete-with-shift, and offers results to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module krt_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire krt_pkg::cmd_t                 command,
    input  wire logic signed [krt_pkg::KEY_W-1:0] key,
    input  wire logic [krt_pkg::TAG_W-1:0]     name_tag,
    input  wire logic [krt_pkg::SCORE_W-1:0]   score,
    input  wire logic                          out_free,
    output krt_pkg::emit_t                     emit,
    output krt_pkg::ctrl_stat_t                stat,
    output krt_pkg::ram_req_t                  ram_req,
    input  wire krt_pkg::rec_t                 ram_rdata
);

    krt_pkg::state_t state_reg, state_next;
    krt_pkg::cmd_t   cmd_reg, cmd_next;
    logic signed [krt_pkg::KEY_W-1:0] key_reg, key_next;
    logic [krt_pkg::TAG_W-1:0]   tag_reg, tag_next;
    logic [krt_pkg::SCORE_W-1:0] score_reg, score_next;
    logic [krt_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [krt_pkg::CNT_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [krt_pkg::ADDR_W-1:0]  wr_idx_reg, wr_idx_next;
    logic                        pend_reg, pend_next;
    krt_pkg::rec_t               res_reg, res_next;
    krt_pkg::status_t            res_status_reg, res_status_next;

    logic                        key_hit;
    logic                        more;
    logic [krt_pkg::CNT_W-1:0]   hit_idx;
    krt_pkg::rec_t               upd_rec;

    // shared compare unit and scan helpers
    assign key_hit = pend_reg && (ram_rdata.key == key_reg);
    assign more    = (rd_idx_reg < count_reg);
    assign hit_idx = rd_idx_reg - krt_pkg::CNT_W'(1);
    assign upd_rec = '{key: ram_rdata.key, tag: tag_reg, score: score_reg};

    assign stat.busy  = (state_reg != krt_pkg::S_IDLE);
    assign stat.count = count_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= krt_pkg::S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    // payload and walk indexes
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        tag_reg        <= tag_next;
        score_reg      <= score_next;
        rd_idx_reg     <= rd_idx_next;
        wr_idx_reg     <= wr_idx_next;
        res_reg        <= res_next;
        res_status_reg <= res_status_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        tag_next        = tag_reg;
        score_next      = score_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        pend_next       = pend_reg;
        res_next        = res_reg;
        res_status_next = res_status_reg;
        ram_req         = '0;
        emit            = '0;
        in_stall        = (state_reg != krt_pkg::S_IDLE);

        case (state_reg)
            krt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    key_next   = key;
                    tag_next   = name_tag;
                    score_next = score;
                    state_next = krt_pkg::S_EXEC;
                end
            end

            krt_pkg::S_EXEC:
            begin
                case (cmd_reg)
                    krt_pkg::CMD_APPEND:
                    begin
                        if (count_reg == krt_pkg::CNT_W'(krt_pkg::DEPTH))
                        begin
                            res_status_next = krt_pkg::ST_FULL;
                            res_next        = '0;
                        end
                        else
                        begin
                            ram_req.we      = 1'b1;
                            ram_req.waddr   = count_reg[krt_pkg::ADDR_W-1:0];
                            ram_req.wdata   = '{key: key_reg, tag: tag_reg,
                                                score: score_reg};
                            count_next      = count_reg + krt_pkg::CNT_W'(1);
                            res_status_next = krt_pkg::ST_OK;
                            res_next        = ram_req.wdata;
                        end
                        state_next = krt_pkg::S_EMIT;
                    end
                    krt_pkg::CMD_FIND, krt_pkg::CMD_UPDATE, krt_pkg::CMD_DELETE:
                    begin
                        rd_idx_next = '0;
                        pend_next   = 1'b0;
                        state_next  = krt_pkg::S_SCAN;
                    end
                    krt_pkg::CMD_DUMP:
                    begin
                        rd_idx_next = '0;
                        pend_next   = 1'b0;
                        if (count_reg == '0)
                        begin
                            res_status_next = krt_pkg::ST_EMPTY;
                            res_next        = '0;
                            state_next      = krt_pkg::S_EMIT;
                        end
                        else
                        begin
                            state_next = krt_pkg::S_DUMP;
                        end
                    end
                    default:
                    begin
                        state_next = krt_pkg::S_IDLE;
                    end
                endcase
            end

            // one read issued and one key compared per cycle
            krt_pkg::S_SCAN:
            begin
                if (key_hit)
                begin
                    wr_idx_next     = hit_idx[krt_pkg::ADDR_W-1:0];
                    res_status_next = krt_pkg::ST_OK;
                    pend_next       = 1'b0;
                    if (cmd_reg == krt_pkg::CMD_UPDATE)
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = hit_idx[krt_pkg::ADDR_W-1:0];
                        ram_req.wdata = upd_rec;
                        res_next      = upd_rec;
                    end
                    else
                    begin
                        res_next = ram_rdata;
                    end
                    state_next = krt_pkg::S_EMIT;
                end
                else if (more)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = rd_idx_reg[krt_pkg::ADDR_W-1:0];
                    rd_idx_next   = rd_idx_reg + krt_pkg::CNT_W'(1);
                    pend_next     = 1'b1;
                end
                else
                begin
                    res_status_next = krt_pkg::ST_NOTFOUND;
                    res_next        = '0;
                    pend_next       = 1'b0;
                    state_next      = krt_pkg::S_EMIT;
                end
            end

            // single result beat
            krt_pkg::S_EMIT:
            begin
                emit.valid  = 1'b1;
                emit.status = res_status_reg;
                emit.rec    = res_reg;
                emit.last   = 1'b1;
                if (out_free)
                begin
                    if ((cmd_reg == krt_pkg::CMD_DELETE) &&
                        (res_status_reg == krt_pkg::ST_OK))
                    begin
                        state_next = krt_pkg::S_SHIFT;
                    end
                    else
                    begin
                        state_next = krt_pkg::S_IDLE;
                    end
                end
            end

            // close the gap: entry i+1 read, written back at i next cycle
            krt_pkg::S_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = wr_idx_reg;
                    ram_req.wdata = ram_rdata;
                    wr_idx_next   = wr_idx_reg + krt_pkg::ADDR_W'(1);
                end
                if (more)
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = rd_idx_reg[krt_pkg::ADDR_W-1:0];
                    rd_idx_next   = rd_idx_reg + krt_pkg::CNT_W'(1);
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - krt_pkg::CNT_W'(1);
                        state_next = krt_pkg::S_IDLE;
                    end
                end
            end

            // stream every record; read data holds while the output stalls
            krt_pkg::S_DUMP:
            begin
                if (pend_reg)
                begin
                    emit.valid  = 1'b1;
                    emit.status = krt_pkg::ST_OK;
                    emit.rec    = ram_rdata;
                    emit.last   = !more;
                    if (out_free)
                    begin
                        if (more)
                        begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = rd_idx_reg[krt_pkg::ADDR_W-1:0];
                            rd_idx_next   = rd_idx_reg + krt_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            pend_next  = 1'b0;
                            state_next = krt_pkg::S_IDLE;
                        end
                    end
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = rd_idx_reg[krt_pkg::ADDR_W-1:0];
                    rd_idx_next   = rd_idx_reg + krt_pkg::CNT_W'(1);
                    pend_next     = 1'b1;
                end
            end

            default:
            begin
                state_next = krt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/keyed_record_table_core.sv
// ----------------------------------------------------------------------------
// keyed_record_table_core
// Ordered table of keyed records with append, find, update, delete and dump.
// ----------------------------------------------------------------------------
// One command beat is taken at a time; in_stall stays high until the command
// has finished. Records live in a single-port-read memory and every command
// that searches walks it one entry per cycle through one key comparator. A
// delete adds a shift pass after its result, and a dump streams one record
// per cycle while the output is not stalled. Only the first matching key is
// touched. Results go through an output register, so the next command may
// start while a result waits.
`default_nettype none

module keyed_record_table_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [krt_pkg::CMD_W-1:0]           command,
    input  wire logic signed [krt_pkg::KEY_W-1:0]    key,
    input  wire logic [krt_pkg::TAG_W-1:0]           name_tag,
    input  wire logic [krt_pkg::SCORE_W-1:0]         score,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [1:0]                               status,
    output logic signed [krt_pkg::KEY_W-1:0]         out_key,
    output logic [krt_pkg::TAG_W-1:0]                out_name_tag,
    output logic [krt_pkg::SCORE_W-1:0]              out_score,
    output logic                                     last
);

    krt_pkg::emit_t      emit;
    krt_pkg::ctrl_stat_t stat;
    krt_pkg::ram_req_t   ram_req;
    krt_pkg::rec_t       ram_rdata;
    logic [krt_pkg::REC_W-1:0] rdata_raw;
    logic                out_free;

    logic                      out_valid_reg;
    krt_pkg::status_t          status_reg;
    krt_pkg::rec_t             out_rec_reg;
    logic                      last_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign ram_rdata = krt_pkg::rec_t'(rdata_raw);

    krt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .key       (key),
        .name_tag  (name_tag),
        .score     (score),
        .out_free  (out_free),
        .emit      (emit),
        .stat      (stat),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    krt_ram #(
        .DEPTH  (krt_pkg::DEPTH),
        .ADDR_W (krt_pkg::ADDR_W),
        .DATA_W (krt_pkg::REC_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (rdata_raw)
    );

    // output beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit.valid;
        end
    end

    // output beat payload
    always_ff @(posedge clk)
    begin
        if (out_free && emit.valid)
        begin
            status_reg  <= emit.status;
            out_rec_reg <= emit.rec;
            last_reg    <= emit.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_key      = out_rec_reg.key;
    assign out_name_tag = out_rec_reg.tag;
    assign out_score    = out_rec_reg.score;
    assign last         = last_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= krt_pkg::CNT_W'(krt_pkg::DEPTH))
        else $error("record count beyond table depth");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != krt_pkg::ST_OK)) |->
        (out_rec_reg == '0) && last_reg)
        else $error("error beat with payload or without last");

    a_nonlast_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (status_reg == krt_pkg::ST_OK))
        else $error("non-final beat with error status");

    a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.busy |-> !emit.valid)
        else $error("result offered while sequencer idle");

endmodule

`default_nettype wire
